### hw/rtl/abp_pkg.sv
// Shared types, constants and helpers for the axis-sort block partitioner.
// No dependencies.
package abp_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int MAX_GROUPS_DEF = 16;

  localparam int CoordW = 32;
  localparam int WeightW = 16;
  localparam int GrpW = 5;
  localparam int PartW = 12;
  localparam int IdxW = 6;
  localparam int CfgW = 5;
  localparam int CfgAddrW = 2;

  localparam logic [CfgAddrW-1:0] REG_WEIGHTED = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_GROUPS_X = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_GROUPS_Y = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_GROUPS_Z = 2'd3;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
    logic [WeightW-1:0]       w;
  } pt_t;

  typedef struct packed {
    logic            weighted;
    logic [GrpW-1:0] gx;
    logic [GrpW-1:0] gy;
    logic [GrpW-1:0] gz;
  } cfg_t;

  // Zero means one group; counts above the limit saturate.
  function automatic logic [GrpW-1:0] eff_groups(logic [GrpW-1:0] g, int maxg);
    logic [GrpW-1:0] r;
    r = g;
    if (g == '0) r = GrpW'(1);
    else if (int'(g) > maxg) r = GrpW'(maxg);
    return r;
  endfunction

endpackage

### hw/rtl/abp_point_mem.sv
// Point store: coordinates and weight, one write and one registered read port.
// Depends on abp_pkg.
module abp_point_mem #(
  parameter int DEPTH = abp_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  abp_pkg::pt_t             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output abp_pkg::pt_t             rdata
);
  import abp_pkg::*;

  pt_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/abp_ctrl.sv
// Load counter, rank sort, axis split and result sequencer.
// Holds the sorted order and partition memories. Depends on abp_pkg.
module abp_ctrl #(
  parameter int MAX_POINTS = abp_pkg::MAX_POINTS_DEF,
  parameter int MAX_GROUPS = abp_pkg::MAX_GROUPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          last_point,
  input  logic [abp_pkg::WeightW-1:0]   weight,
  input  abp_pkg::cfg_t                 cfg,
  input  abp_pkg::pt_t                  pt_rdata,
  output logic                          busy,
  output logic                          pt_we,
  output logic [$clog2(MAX_POINTS)-1:0] pt_waddr,
  output logic [$clog2(MAX_POINTS)-1:0] pt_raddr,
  output logic                          result_valid,
  output logic [abp_pkg::IdxW-1:0]      point_index,
  output logic [abp_pkg::PartW-1:0]     partition_id,
  output logic                          overflow,
  output logic                          last_result
);
  import abp_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int TW0 = WeightW + CW;
  localparam int TW = TW0 + GrpW;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SETUP    = 4'd1;
  localparam logic [3:0] S_DIV      = 4'd2;
  localparam logic [3:0] S_RK_RD    = 4'd3;
  localparam logic [3:0] S_RK_LAT   = 4'd4;
  localparam logic [3:0] S_RK_SCAN  = 4'd5;
  localparam logic [3:0] S_RK_DRAIN = 4'd6;
  localparam logic [3:0] S_WK_INIT  = 4'd7;
  localparam logic [3:0] S_WK_RD    = 4'd8;
  localparam logic [3:0] S_WK_P     = 4'd9;
  localparam logic [3:0] S_WK_UPD   = 4'd10;
  localparam logic [3:0] S_EMIT     = 4'd11;
  localparam logic [3:0] S_EMIT_END = 4'd12;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  logic [3:0]       state;
  logic [1:0]       axis;
  logic [CW-1:0]    count;
  logic             dropped;
  logic [TW0-1:0]   total;
  logic [CW-1:0]    n_run;
  logic             ovf_run;
  logic [TW0-1:0]   tot_run;
  logic [GrpW-1:0]  g;
  logic [PartW-1:0] mult;
  logic [CW-1:0]    q;
  logic [CW-1:0]    r;
  logic [AW-1:0]    i;
  logic [AW-1:0]    j;
  logic [AW-1:0]    k;
  logic [AW-1:0]    cmp_j;
  logic             cmp_v;
  logic [AW-1:0]    rank;
  logic [CoordW-1:0] key_i;
  logic [AW-1:0]    p;
  logic [GrpW-1:0]  cg;
  logic [CW-1:0]    cnt;
  logic [GrpW-1:0]  wj;
  logic [TW-1:0]    thr;
  logic [TW-1:0]    accg;
  logic [AW-1:0]    oidx;
  logic             olast;

  logic [AW-1:0]    srt_mem [MAX_POINTS];
  logic [AW-1:0]    srt_rd;
  logic [PartW-1:0] part_mem [MAX_POINTS];
  logic [PartW-1:0] part_rd;
  logic [AW-1:0]    part_raddr;
  logic             part_we;
  logic [PartW-1:0] part_wdata;

  logic             accept;
  logic             stored;
  logic [CoordW-1:0] key_rd;
  logic             less;
  logic [GrpW-1:0]  nx;
  logic [GrpW-1:0]  ny;
  logic [GrpW-1:0]  nz;
  logic             adv;
  logic [GrpW-1:0]  grp;
  logic [CW:0]      size;
  logic             last_pos;

  assign accept = start && (state == S_IDLE);
  assign stored = (32'(count) < MAX_POINTS);
  assign pt_we = accept && stored;
  assign pt_waddr = count[AW-1:0];
  assign busy = (state != S_IDLE);

  assign nx = eff_groups(cfg.gx, MAX_GROUPS);
  assign ny = eff_groups(cfg.gy, MAX_GROUPS);
  assign nz = eff_groups(cfg.gz, MAX_GROUPS);

  always_comb begin
    case (axis)
      AX_X:    key_rd = pt_rdata.x;
      AX_Y:    key_rd = pt_rdata.y;
      default: key_rd = pt_rdata.z;
    endcase
  end

  // Equal keys rank by load order, which keeps the sort stable.
  assign less = ($signed(key_rd) < $signed(key_i)) || ((key_rd == key_i) && (cmp_j < i));

  always_comb begin
    case (state)
      S_RK_RD:  pt_raddr = i;
      S_WK_P:   pt_raddr = srt_rd;
      S_WK_UPD: pt_raddr = p;
      default:  pt_raddr = j;
    endcase
    case (state)
      S_WK_P:  part_raddr = srt_rd;
      S_EMIT:  part_raddr = k;
      default: part_raddr = p;
    endcase
  end

  assign adv = cfg.weighted && (wj < g - GrpW'(1)) && (accg >= thr);
  assign grp = cfg.weighted ? wj : cg;
  assign size = (32'(cg) < 32'(r)) ? ((CW+1)'(q) + 1'b1) : (CW+1)'(q);
  assign last_pos = ((CW)'(k) == n_run - 1'b1);
  assign part_we = (state == S_WK_UPD) && !adv;
  assign part_wdata = ((axis == AX_X) ? '0 : part_rd) + PartW'(mult * grp);

  always_ff @(posedge clk) begin
    srt_rd <= srt_mem[k];
    if (state == S_RK_DRAIN) begin
      srt_mem[rank + AW'(less)] <= i;
    end
    part_rd <= part_mem[part_raddr];
    if (part_we) begin
      part_mem[p] <= part_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      dropped <= 1'b0;
      total <= '0;
      result_valid <= 1'b0;
      cmp_v <= 1'b0;
      axis <= AX_X;
    end else begin
      result_valid <= (state == S_EMIT);
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (last_point) begin
              n_run <= count + CW'(stored);
              ovf_run <= dropped || !stored;
              tot_run <= total + (stored ? TW0'(weight) : '0);
              count <= '0;
              dropped <= 1'b0;
              total <= '0;
              axis <= AX_X;
              state <= S_SETUP;
            end else if (stored) begin
              count <= count + 1'b1;
              total <= total + TW0'(weight);
            end else begin
              dropped <= 1'b1;
            end
          end
        end
        S_SETUP: begin
          case (axis)
            AX_X: begin
              g <= nx;
              mult <= PartW'(1);
            end
            AX_Y: begin
              g <= ny;
              mult <= PartW'(nx);
            end
            default: begin
              g <= nz;
              mult <= PartW'(nx) * PartW'(ny);
            end
          endcase
          q <= '0;
          r <= n_run;
          state <= S_DIV;
        end
        // Even split sizes by repeated subtraction: q = n / g, r = n mod g.
        S_DIV: begin
          if (32'(r) >= 32'(g)) begin
            r <= r - CW'(g);
            q <= q + 1'b1;
          end else begin
            i <= '0;
            state <= S_RK_RD;
          end
        end
        S_RK_RD: state <= S_RK_LAT;
        S_RK_LAT: begin
          key_i <= key_rd;
          j <= '0;
          rank <= '0;
          cmp_v <= 1'b0;
          state <= S_RK_SCAN;
        end
        S_RK_SCAN: begin
          cmp_v <= 1'b1;
          cmp_j <= j;
          if (cmp_v && less) rank <= rank + 1'b1;
          if (CW'(j) == n_run - 1'b1) state <= S_RK_DRAIN;
          else j <= j + 1'b1;
        end
        S_RK_DRAIN: begin
          cmp_v <= 1'b0;
          if (CW'(i) == n_run - 1'b1) begin
            state <= S_WK_INIT;
          end else begin
            i <= i + 1'b1;
            state <= S_RK_RD;
          end
        end
        S_WK_INIT: begin
          k <= '0;
          cg <= '0;
          cnt <= '0;
          wj <= '0;
          thr <= TW'(tot_run);
          accg <= '0;
          state <= S_WK_RD;
        end
        S_WK_RD: state <= S_WK_P;
        S_WK_P: begin
          p <= srt_rd;
          state <= S_WK_UPD;
        end
        S_WK_UPD: begin
          if (adv) begin
            wj <= wj + 1'b1;
            thr <= thr + TW'(tot_run);
          end else begin
            if (cfg.weighted) begin
              accg <= accg + TW'(pt_rdata.w) * TW'(g);
            end else if ((CW+1)'(cnt) + 1'b1 == size) begin
              cg <= cg + 1'b1;
              cnt <= '0;
            end else begin
              cnt <= cnt + 1'b1;
            end
            if (last_pos) begin
              k <= '0;
              if (axis == AX_Z) begin
                state <= S_EMIT;
              end else begin
                axis <= axis + 1'b1;
                state <= S_SETUP;
              end
            end else begin
              k <= k + 1'b1;
              state <= S_WK_RD;
            end
          end
        end
        S_EMIT: begin
          if (last_pos) state <= S_EMIT_END;
          else k <= k + 1'b1;
        end
        S_EMIT_END: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    oidx <= k;
    olast <= last_pos;
  end

  assign point_index = IdxW'(oidx);
  assign partition_id = part_rd;
  assign overflow = ovf_run;
  assign last_result = result_valid && olast;

endmodule

### hw/rtl/axis_sort_block_partitioner_core.sv
// Axis-sort block partitioner. Points load one per cycle (busy low).
// The item marked last starts the run; per axis: split sizing, a rank sort
// over the point memory's read port and a split walk; then n result beats,
// one per cycle, the last one in the final busy cycle. Results cannot be
// stalled. Synchronous reset empties the set and sets weighted_mode 0, all
// group counts 1.
module axis_sort_block_partitioner_core #(
  parameter int MAX_POINTS = abp_pkg::MAX_POINTS_DEF,
  parameter int MAX_GROUPS = abp_pkg::MAX_GROUPS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [abp_pkg::CoordW-1:0]   coord_x,
  input  logic signed [abp_pkg::CoordW-1:0]   coord_y,
  input  logic signed [abp_pkg::CoordW-1:0]   coord_z,
  input  logic [abp_pkg::WeightW-1:0]         weight,
  input  logic                                last_point,
  input  logic                                cfg_wr_en,
  input  logic [abp_pkg::CfgAddrW-1:0]        cfg_index,
  input  logic [abp_pkg::CfgW-1:0]            cfg_data,
  output logic                                result_valid,
  output logic [abp_pkg::IdxW-1:0]            point_index,
  output logic [abp_pkg::PartW-1:0]           partition_id,
  output logic                                overflow,
  output logic                                last_result
);
  import abp_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);

  cfg_t          cfg;
  pt_t           pt_wdata;
  pt_t           pt_rdata;
  logic          pt_we;
  logic [AW-1:0] pt_waddr;
  logic [AW-1:0] pt_raddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.weighted <= 1'b0;
      cfg.gx <= GrpW'(1);
      cfg.gy <= GrpW'(1);
      cfg.gz <= GrpW'(1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WEIGHTED: cfg.weighted <= cfg_data[0];
        REG_GROUPS_X: cfg.gx <= cfg_data;
        REG_GROUPS_Y: cfg.gy <= cfg_data;
        REG_GROUPS_Z: cfg.gz <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pt_wdata.x = coord_x;
  assign pt_wdata.y = coord_y;
  assign pt_wdata.z = coord_z;
  assign pt_wdata.w = weight;

  abp_point_mem #(.DEPTH(MAX_POINTS)) u_mem (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  abp_ctrl #(.MAX_POINTS(MAX_POINTS), .MAX_GROUPS(MAX_GROUPS)) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_point   (last_point),
    .weight       (weight),
    .cfg          (cfg),
    .pt_rdata     (pt_rdata),
    .busy         (busy),
    .pt_we        (pt_we),
    .pt_waddr     (pt_waddr),
    .pt_raddr     (pt_raddr),
    .result_valid (result_valid),
    .point_index  (point_index),
    .partition_id (partition_id),
    .overflow     (overflow),
    .last_result  (last_result)
  );

endmodule

### hw/rtl/abp_checker.sv
// Port-level checks for the partitioner, bound to the top level.
// Depends on abp_pkg.
module abp_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         busy,
  input logic                         result_valid,
  input logic [abp_pkg::IdxW-1:0]     point_index,
  input logic                         last_result
);
  import abp_pkg::*;

  a_idle_after_rst: assert property (@(posedge clk) rst |=> !busy)
    else $error("busy after reset");

  a_res_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result beat outside a run");

  a_last_marks: assert property (@(posedge clk) disable iff (rst)
    last_result |-> result_valid)
    else $error("last_result without beat");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_result) |=>
      (result_valid && point_index == $past(point_index) + 1'b1))
    else $error("result burst broken");

  a_burst_end: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |=> !result_valid)
    else $error("beat after last result");

endmodule

bind axis_sort_block_partitioner_core abp_checker u_abp_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .result_valid (result_valid),
  .point_index  (point_index),
  .last_result  (last_result)
);

### bench/axis_sort_block_partitioner_core_test.sv
// Self-checking bench for axis_sort_block_partitioner_core: loads point sets,
// predicts the partition id of every point and checks each result beat.
// Depends on abp_pkg and the core RTL only.
`timescale 1ns / 100ps

module axis_sort_block_partitioner_core_test;
  import abp_pkg::*;

  localparam int NPTS = MAX_POINTS_DEF;
  localparam int NGRP = MAX_GROUPS_DEF;
  localparam int N_ITEMS = 280;

  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [PartW-1:0] pid;
    logic             ovf;
    logic             lastr;
  } part_beat_t;

  typedef struct {
    logic signed [CoordW-1:0] x, y, z;
    logic [WeightW-1:0]       w;
    logic                     lst;
    int                       fixed_pid;  // -1: use predictor
  } pt_row_t;

  logic clk, rst, start, busy;
  logic signed [CoordW-1:0] coord_x, coord_y, coord_z;
  logic [WeightW-1:0] weight;
  logic last_point, cfg_wr_en;
  logic [CfgAddrW-1:0] cfg_index;
  logic [CfgW-1:0] cfg_data;
  logic result_valid, overflow, last_result;
  logic [IdxW-1:0] point_index;
  logic [PartW-1:0] partition_id;

  axis_sort_block_partitioner_core dut (.*);

  // predictor state
  logic signed [CoordW-1:0] pt_coord[3][NPTS];
  logic [WeightW-1:0] pt_w[NPTS];
  int order[NPTS];
  int pid_acc[NPTS];
  int n_loaded;
  bit dropped;
  bit m_weighted;
  int m_grp[3];

  part_beat_t pending_parts[$];
  int errors;
  int items_sent;
  bit idle_on;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int clamp_groups(int g);
    if (g == 0) return 1;
    if (g > NGRP) return NGRP;
    return g;
  endfunction

  // stable insertion sort by signed coordinate
  function automatic void sort_points(int ax, int n);
    int cur, k;
    for (int i = 0; i < n; i++) order[i] = i;
    for (int i = 1; i < n; i++) begin
      cur = order[i];
      k = i;
      while (k > 0 && pt_coord[ax][order[k-1]] > pt_coord[ax][cur]) begin
        order[k] = order[k-1];
        k--;
      end
      order[k] = cur;
    end
  endfunction

  function automatic void split_groups(int n, int g, int mult, longint unsigned total);
    longint unsigned acc;
    int i, jump, extra, head, grp;
    i = 0;
    acc = 0;
    if (m_weighted) begin
      for (int j = 0; j + 1 < g; j++)
        while (i < n && acc * g < total * (j + 1)) begin
          acc += pt_w[order[i]];
          pid_acc[order[i]] += mult * j;
          i++;
        end
      for (; i < n; i++) pid_acc[order[i]] += mult * (g - 1);
    end else begin
      jump = n / g;
      extra = n - jump * g;
      head = extra * (jump + 1);
      for (i = 0; i < n; i++) begin
        if (i < head) grp = i / (jump + 1);
        else grp = extra + (i - head) / jump;
        pid_acc[order[i]] += mult * grp;
      end
    end
  endfunction

  // called for every accepted point beat
  function automatic void load_point(pt_row_t r);
    longint unsigned total;
    int nx, ny, nz;
    part_beat_t b;
    if (n_loaded < NPTS) begin
      pt_coord[0][n_loaded] = r.x;
      pt_coord[1][n_loaded] = r.y;
      pt_coord[2][n_loaded] = r.z;
      pt_w[n_loaded] = r.w;
      n_loaded++;
    end else dropped = 1;
    if (!r.lst) return;
    nx = clamp_groups(m_grp[0]);
    ny = clamp_groups(m_grp[1]);
    nz = clamp_groups(m_grp[2]);
    total = 0;
    for (int i = 0; i < n_loaded; i++) begin
      pid_acc[i] = 0;
      total += pt_w[i];
    end
    sort_points(0, n_loaded);
    split_groups(n_loaded, nx, 1, total);
    sort_points(1, n_loaded);
    split_groups(n_loaded, ny, nx, total);
    sort_points(2, n_loaded);
    split_groups(n_loaded, nz, nx * ny, total);
    for (int i = 0; i < n_loaded; i++) begin
      b.idx = IdxW'(i);
      b.pid = (r.fixed_pid >= 0) ? PartW'(r.fixed_pid) : PartW'(pid_acc[i]);
      b.ovf = dropped;
      b.lastr = (i + 1 == n_loaded);
      pending_parts.push_back(b);
    end
    n_loaded = 0;
    dropped = 0;
  endfunction

  always @(posedge clk) begin
    part_beat_t e;
    if (!rst && result_valid) begin
      if (pending_parts.size() == 0) begin
        $display("%0t unexpected result beat idx=%0d pid=%0d", $time, point_index,
                 partition_id);
        errors++;
      end else begin
        e = pending_parts.pop_front();
        if (point_index !== e.idx) begin
          $display("%0t point_index exp %0d got %0d", $time, e.idx, point_index);
          errors++;
        end
        if (partition_id !== e.pid) begin
          $display("%0t partition_id exp %0d got %0d", $time, e.pid, partition_id);
          errors++;
        end
        if (overflow !== e.ovf) begin
          $display("%0t overflow exp %0b got %0b", $time, e.ovf, overflow);
          errors++;
        end
        if (last_result !== e.lastr) begin
          $display("%0t last_result exp %0b got %0b", $time, e.lastr, last_result);
          errors++;
        end
      end
    end
  end

  task automatic send_point(pt_row_t r);
    // each cycle idles with the same odds
    while (idle_on && $urandom_range(99) < 23) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    coord_x <= r.x;
    coord_y <= r.y;
    coord_z <= r.z;
    weight <= r.w;
    last_point <= r.lst;
    do @(posedge clk); while (busy);
    load_point(r);
    items_sent++;
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_parts.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // leaves cfg_wr_en high; the caller drops it after the last write
  task automatic write_reg(logic [CfgAddrW-1:0] idx, logic [CfgW-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_WEIGHTED: m_weighted = val[0];
      REG_GROUPS_X: m_grp[0] = val;
      REG_GROUPS_Y: m_grp[1] = val;
      REG_GROUPS_Z: m_grp[2] = val;
      default: ;
    endcase
  endtask

  function automatic logic [CfgW-1:0] pick_groups();
    case ($urandom_range(9))
      0: return CfgW'(0);
      1: return CfgW'(31);
      2: return CfgW'(16);
      3: return CfgW'($urandom_range(17, 31));
      default: return CfgW'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic signed [CoordW-1:0] pick_coord(bit ties);
    if (ties)
      case ($urandom_range(4))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 0;
        3: return -1;
        default: return 1;
      endcase
    return $urandom;
  endfunction

  pt_row_t dir_rows[] = '{
    '{32'sh7fff_ffff, 32'sh8000_0000, 0, 16'hffff, 1'b1, 0},
    '{32'sh8000_0000, 32'sh7fff_ffff, -1, 16'h0000, 1'b0, 0},
    '{32'sh7fff_ffff, 32'sh8000_0000, 1, 16'hffff, 1'b0, 0},
    '{0, 0, 32'sh7fff_ffff, 16'h0001, 1'b0, 0},
    '{-1, -1, 32'sh8000_0000, 16'h8000, 1'b1, 0},
    '{32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 16'h5555, 1'b0, -1},
    '{32'shaaaa_aaaa, 32'sh5555_5555, 32'shf0f0_f0f0, 16'haaaa, 1'b0, -1},
    '{32'sh5555_5555, 32'sh5555_5555, 32'sh0f0f_0f0f, 16'h0000, 1'b1, 0}
  };

  initial begin
    pt_row_t r;
    int set_len, kind, phase;
    bit ties;
    rst = 1;
    start = 0;
    coord_x = 0;
    coord_y = 0;
    coord_z = 0;
    weight = 0;
    last_point = 0;
    cfg_wr_en = 0;
    cfg_index = REG_WEIGHTED;
    cfg_data = 0;
    errors = 0;
    items_sent = 0;
    n_loaded = 0;
    dropped = 0;
    m_weighted = 0;
    m_grp = '{1, 1, 1};
    idle_on = 1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: one group per axis, so every id is zero
    foreach (dir_rows[i]) send_point(dir_rows[i]);
    drain_results();

    phase = 0;
    while (items_sent < N_ITEMS) begin
      if (phase == 1) begin
        write_reg(REG_WEIGHTED, CfgW'(1));
        write_reg(REG_GROUPS_X, CfgW'(31));
        write_reg(REG_GROUPS_Y, CfgW'(0));
        write_reg(REG_GROUPS_Z, CfgW'(16));
      end else if (phase == 2) begin
        write_reg(REG_WEIGHTED, CfgW'(0));
        write_reg(REG_GROUPS_X, CfgW'(16));
        write_reg(REG_GROUPS_Y, CfgW'(16));
        write_reg(REG_GROUPS_Z, CfgW'(16));
      end else begin
        write_reg(REG_WEIGHTED, CfgW'($urandom));
        write_reg(REG_GROUPS_X, pick_groups());
        write_reg(REG_GROUPS_Y, pick_groups());
        write_reg(REG_GROUPS_Z, pick_groups());
      end
      cfg_wr_en <= 1'b0;
      idle_on = !(phase >= 6 && phase < 10);
      kind = $urandom_range(9);
      // one set runs past capacity to exercise the drop flag
      if (phase == 4) set_len = NPTS + 3;
      else if (kind == 0) set_len = 1;
      else set_len = $urandom_range(2, 20);
      ties = (kind >= 7);
      for (int i = 0; i < set_len; i++) begin
        r.x = pick_coord(ties);
        r.y = pick_coord(ties);
        r.z = pick_coord(ties);
        case (kind)
          1: r.w = '0;
          2: r.w = $urandom_range(1) ? 16'hffff : 16'h0000;
          default: r.w = WeightW'($urandom);
        endcase
        r.lst = (i == set_len - 1);
        r.fixed_pid = -1;
        send_point(r);
      end
      drain_results();
      phase++;
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
